### design/scytale_transposition_unit_assert.svh
// Assertion macros shared by the scytale transposition design.
// Needs clk and rst_n in the scope of each use.
`ifndef SCYTALE_TRANSPOSITION_UNIT_ASSERT_SVH
`define SCYTALE_TRANSPOSITION_UNIT_ASSERT_SVH

// Same-cycle implication
`define STU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define STU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sct_pkg.sv
// Package for the scytale transposition unit: constants, word types and the
// job descriptor passed from the load side to the read sequencer. No dependencies.
package sct_pkg;

    // Buffer depth default and fixed field widths
    localparam int MSG_DEPTH_DEF = 32;
    localparam int CNT_W         = 6;   // holds a count of up to 32 bytes
    localparam int ROW_W         = 6;   // key_rows field width
    localparam int RIDX_W        = 5;   // row index 0..31
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 6;

    localparam logic [ROW_W-1:0] MAX_ROWS = 6'd32;

    localparam logic [7:0] PAD_CHAR   = 8'h40;   // '@'
    localparam logic [7:0] SPACE_CHAR = 8'h20;   // ' '

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROWS = 1'b1;

    // Mode codes
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
        logic       truncated;
    } out_word_t;

    // One message handed to the sequencer
    typedef struct packed {
        logic             go;
        logic             mode;
        logic [ROW_W-1:0] rows;    // effective rows, 1..32
        logic [CNT_W-1:0] n;       // bytes to transpose
        logic             trunc;
    } sct_job_t;

    // Sequencer status toward the load side
    typedef struct packed {
        logic      idle;
        logic      res_vld;
        out_word_t res;
    } sct_stat_t;

endpackage

### design/scytale_transposition_unit.sv
// Scytale transposition unit, top level: load side, config registers,
// output register. Depends on sct_pkg, sct_buf, sct_seq and the assertion header.
//
//  port group   dir  handshake              word
//  in           in   in_valid / in_ready    sct_pkg::in_word_t
//  out          out  out_valid / out_ready  sct_pkg::out_word_t
//  cfg          in   cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// Loading takes one byte per cycle; in_ready drops from the last byte until
// the sequencer has handed its final word to the output register.
// Encrypt first counts columns by repeated addition; decrypt starts at once.
// Each result word then takes a buffer read, then a hand-off.
// A stalled output holds the sequencer in its hand-off step.
// Reset is asynchronous; it clears load counters and control, not buffer or job regs.
`include "scytale_transposition_unit_assert.svh"

module scytale_transposition_unit #(
    parameter int MSG_DEPTH = sct_pkg::MSG_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  sct_pkg::in_word_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output sct_pkg::out_word_t                 out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sct_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(MSG_DEPTH);
    localparam int CW = sct_pkg::CNT_W;

    logic                      mode_reg;
    logic [sct_pkg::ROW_W-1:0] key_rows_reg;
    logic [CW-1:0]             raw_cnt_reg, raw_cnt_next;
    logic [CW-1:0]             ns_cnt_reg, ns_cnt_next;
    logic                      ovf_reg, ovf_next;
    logic                      out_vld_reg;
    sct_pkg::out_word_t        out_data_reg;

    logic                      in_fire;
    logic                      has_room;
    logic                      not_space;
    logic [CW-1:0]             raw_after, ns_after;
    logic                      trunc_after;
    logic [sct_pkg::ROW_W-1:0] eff_rows;
    logic                      res_take;
    logic                      rd_en, rd_sel;
    logic [AW-1:0]             rd_addr;
    logic [7:0]                rd_data;
    sct_pkg::sct_job_t         job;
    sct_pkg::sct_stat_t        stat;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= sct_pkg::MODE_ENCRYPT;
            key_rows_reg <= sct_pkg::ROW_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sct_pkg::REG_MODE:     mode_reg     <= cfg_wdata[0];
                sct_pkg::REG_KEY_ROWS: key_rows_reg <= cfg_wdata[sct_pkg::ROW_W-1:0];
                default:               ;
            endcase
        end
    end

    // Load side
    assign in_ready  = stat.idle;
    assign in_fire   = in_valid && in_ready;
    assign has_room  = (raw_cnt_reg < CW'(MSG_DEPTH));
    assign not_space = (in_data.in_char != sct_pkg::SPACE_CHAR);

    always_comb
    begin
        raw_after   = has_room ? (raw_cnt_reg + 1'b1) : raw_cnt_reg;
        ns_after    = (has_room && not_space) ? (ns_cnt_reg + 1'b1) : ns_cnt_reg;
        trunc_after = ovf_reg || !has_room;
        if (key_rows_reg == '0)
        begin
            eff_rows = sct_pkg::ROW_W'(1);
        end
        else if (key_rows_reg > sct_pkg::MAX_ROWS)
        begin
            eff_rows = sct_pkg::MAX_ROWS;
        end
        else
        begin
            eff_rows = key_rows_reg;
        end
        raw_cnt_next = raw_cnt_reg;
        ns_cnt_next  = ns_cnt_reg;
        ovf_next     = ovf_reg;
        if (in_fire)
        begin
            if (in_data.in_last)
            begin
                raw_cnt_next = '0;
                ns_cnt_next  = '0;
                ovf_next     = 1'b0;
            end
            else
            begin
                raw_cnt_next = raw_after;
                ns_cnt_next  = ns_after;
                ovf_next     = trunc_after;
            end
        end
    end

    // Job descriptor at the last byte
    always_comb
    begin
        job.go    = in_fire && in_data.in_last;
        job.mode  = mode_reg;
        job.rows  = eff_rows;
        job.n     = (mode_reg == sct_pkg::MODE_DECRYPT) ? raw_after : ns_after;
        job.trunc = trunc_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_cnt_reg <= '0;
            ns_cnt_reg  <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            raw_cnt_reg <= raw_cnt_next;
            ns_cnt_reg  <= ns_cnt_next;
            ovf_reg     <= ovf_next;
        end
    end

    sct_buf #(
        .MSG_DEPTH (MSG_DEPTH)
    ) u_buf (
        .clk         (clk),
        .wr_en       (in_fire && has_room),
        .wr_ns       (not_space),
        .wr_raw_addr (AW'(raw_cnt_reg)),
        .wr_ns_addr  (AW'(ns_cnt_reg)),
        .wr_data     (in_data.in_char),
        .rd_en       (rd_en),
        .rd_sel      (rd_sel),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    sct_seq #(
        .MSG_DEPTH (MSG_DEPTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job),
        .res_take (res_take),
        .stat     (stat),
        .rd_en    (rd_en),
        .rd_sel   (rd_sel),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // Output register
    assign res_take = stat.res_vld && (!out_vld_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= stat.res;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    `STU_ASSERT_NXT(a_last_clears, in_fire && in_data.in_last,
        (raw_cnt_reg == '0) && (ns_cnt_reg == '0) && !ovf_reg,
        "counts not cleared after last word")
    `STU_ASSERT_IMP(a_ns_le_raw, 1'b1, ns_cnt_reg <= raw_cnt_reg, "stripped count above raw count")
    `STU_ASSERT_NXT(a_out_stable, out_valid && !out_ready,
        out_valid && $stable(out_data), "output word changed while stalled")

endmodule

### design/sct_buf.sv
// Message buffer: raw byte memory and space-stripped memory, one read port
// with registered data. Depends on sct_pkg.
module sct_buf #(
    parameter int MSG_DEPTH = sct_pkg::MSG_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic                         wr_ns,
    input  logic [$clog2(MSG_DEPTH)-1:0] wr_raw_addr,
    input  logic [$clog2(MSG_DEPTH)-1:0] wr_ns_addr,
    input  logic [7:0]                   wr_data,
    input  logic                         rd_en,
    input  logic                         rd_sel,
    input  logic [$clog2(MSG_DEPTH)-1:0] rd_addr,
    output logic [7:0]                   rd_data
);

    logic [7:0] raw_mem [MSG_DEPTH];
    logic [7:0] ns_mem  [MSG_DEPTH];
    logic [7:0] rd_data_reg;

    // Raw store: every kept byte in arrival order
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            raw_mem[wr_raw_addr] <= wr_data;
        end
    end

    // Stripped store: non-space bytes only
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_ns)
        begin
            ns_mem[wr_ns_addr] <= wr_data;
        end
    end

    // Registered read, select by mode
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (rd_sel == sct_pkg::MODE_DECRYPT)
            begin
                rd_data_reg <= raw_mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= ns_mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/sct_seq.sv
// Read sequencer: column count by repeated addition (encrypt), then one buffer
// read per result word in grid order. Depends on sct_pkg and the assertion header.
`include "scytale_transposition_unit_assert.svh"

module sct_seq #(
    parameter int MSG_DEPTH = sct_pkg::MSG_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sct_pkg::sct_job_t            job,
    input  logic                         res_take,
    output sct_pkg::sct_stat_t           stat,
    output logic                         rd_en,
    output logic                         rd_sel,
    output logic [$clog2(MSG_DEPTH)-1:0] rd_addr,
    input  logic [7:0]                   rd_data
);

    localparam int AW = $clog2(MSG_DEPTH);
    localparam int CW = sct_pkg::CNT_W;
    localparam int RW = sct_pkg::RIDX_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_GEOM = 4'b0010,
        S_READ = 4'b0100,
        S_HOLD = 4'b1000
    } seq_state_t;

    seq_state_t state_reg, state_next;
    logic                        mode_reg, mode_next;
    logic                        trunc_reg, trunc_next;
    logic [sct_pkg::ROW_W-1:0]   rows_reg, rows_next;
    logic [CW-1:0]               n_reg, n_next;
    logic [CW:0]                 acc_reg, acc_next;
    logic [CW-1:0]               cols_reg, cols_next;
    logic [CW-1:0]               full_reg, full_next;
    logic [RW-1:0]               r_reg, r_next;
    logic [RW-1:0]               c_reg, c_next;
    logic [CW-1:0]               base_reg, base_next;

    logic [CW:0]   enc_sum;
    logic [CW:0]   dec_step;
    logic [CW-1:0] rows_used;
    logic [CW-1:0] enc_len;
    logic          enc_last_col, enc_last_row, enc_pad;
    logic          dec_more, dec_last_row;
    logic          word_last;

    // Grid position decode
    always_comb
    begin
        enc_sum      = {1'b0, base_reg} + {2'b00, c_reg};
        dec_step     = {1'b0, base_reg} + {1'b0, rows_reg};
        rows_used    = (rows_reg < n_reg) ? rows_reg : n_reg;
        enc_last_col = ({1'b0, c_reg} == (cols_reg - 1'b1));
        enc_last_row = ({1'b0, r_reg} == (rows_reg - 1'b1));
        enc_pad      = enc_last_col && ({1'b0, r_reg} >= full_reg);
        enc_len      = ({1'b0, r_reg} < full_reg) ? cols_reg : (cols_reg - 1'b1);
        dec_more     = (dec_step < {1'b0, n_reg});
        dec_last_row = ({1'b0, r_reg} == (rows_used - 1'b1));
        if (mode_reg == sct_pkg::MODE_DECRYPT)
        begin
            word_last = !dec_more && dec_last_row;
            rd_addr   = AW'(base_reg);
        end
        else
        begin
            word_last = enc_last_col && enc_last_row;
            rd_addr   = AW'(enc_sum);
        end
    end

    assign rd_en  = (state_reg == S_READ);
    assign rd_sel = mode_reg;

    // Result word and status
    always_comb
    begin
        stat.idle               = (state_reg == S_IDLE);
        stat.res_vld            = (state_reg == S_HOLD);
        stat.res.out_last       = word_last;
        stat.res.truncated      = trunc_reg;
        if ((mode_reg == sct_pkg::MODE_ENCRYPT) && enc_pad)
        begin
            stat.res.out_char = sct_pkg::PAD_CHAR;
        end
        else
        begin
            stat.res.out_char = rd_data;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        trunc_next = trunc_reg;
        rows_next  = rows_reg;
        n_next     = n_reg;
        acc_next   = acc_reg;
        cols_next  = cols_reg;
        full_next  = full_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        base_next  = base_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (job.go && (job.n != '0))
                begin
                    mode_next  = job.mode;
                    trunc_next = job.trunc;
                    rows_next  = job.rows;
                    n_next     = job.n;
                    acc_next   = '0;
                    cols_next  = '0;
                    r_next     = '0;
                    c_next     = '0;
                    base_next  = '0;
                    state_next = (job.mode == sct_pkg::MODE_DECRYPT) ? S_READ : S_GEOM;
                end
            end
            S_GEOM:
            begin
                // cols = ceil(n / rows) by repeated addition
                if (acc_reg >= {1'b0, n_reg})
                begin
                    full_next  = rows_reg - CW'(acc_reg - {1'b0, n_reg});
                    state_next = S_READ;
                end
                else
                begin
                    acc_next  = acc_reg + {1'b0, rows_reg};
                    cols_next = cols_reg + 1'b1;
                end
            end
            S_READ:
            begin
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (res_take)
                begin
                    if (word_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                        if (mode_reg == sct_pkg::MODE_DECRYPT)
                        begin
                            if (dec_more)
                            begin
                                base_next = CW'(dec_step);
                            end
                            else
                            begin
                                r_next    = r_reg + 1'b1;
                                base_next = CW'(r_reg) + 1'b1;
                            end
                        end
                        else if (enc_last_row)
                        begin
                            r_next    = '0;
                            base_next = '0;
                            c_next    = c_reg + 1'b1;
                        end
                        else
                        begin
                            r_next    = r_reg + 1'b1;
                            base_next = base_reg + enc_len;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Job geometry and counters
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        trunc_reg <= trunc_next;
        rows_reg  <= rows_next;
        n_reg     <= n_next;
        acc_reg   <= acc_next;
        cols_reg  <= cols_next;
        full_reg  <= full_next;
        r_reg     <= r_next;
        c_reg     <= c_next;
        base_reg  <= base_next;
    end

    `STU_ASSERT_NXT(a_read_then_hold, state_reg == S_READ, state_reg == S_HOLD, "read not followed by hold")
    `STU_ASSERT_NXT(a_last_ends_job, res_take && word_last, state_reg == S_IDLE, "job ran past last word")
    `STU_ASSERT_IMP(a_enc_addr_range, (state_reg == S_READ) && (mode_reg == sct_pkg::MODE_ENCRYPT) && !enc_pad, enc_sum < {1'b0, n_reg}, "encrypt read beyond message")

endmodule

### tb/tb_scytale_transposition_unit.sv
// Self-checking testbench for scytale_transposition_unit: directed and random messages
// with stalls on both sides, checked against a transposition model of its own.
// Depends on sct_pkg and the design sources only.
`timescale 1ns / 100ps

module tb_scytale_transposition_unit;

    localparam int STORE_DEPTH   = 32;
    localparam int SETTLE_CYCLES = 80;      // column count before emission, empty messages
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PRINT_LIMIT   = 50;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    sct_pkg::in_word_t              in_data = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    sct_pkg::out_word_t             out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [sct_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sct_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Model state: message buffer, fill count, overflow flag, registers
    logic [7:0]                msg_bytes [STORE_DEPTH];
    int                        msg_len = 0;
    logic                      msg_dropped = 1'b0;
    logic                      cfg_mode = sct_pkg::MODE_ENCRYPT;
    logic [sct_pkg::ROW_W-1:0] cfg_rows = 6'd1;

    sct_pkg::out_word_t pending_text [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_len = 0;
    int rx_hold_left = 0;
    int cycle_count = 0;
    int error_count = 0;
    int words_checked = 0;
    int messages_sent = 0;
    int messages_cut = 0;
    int messages_empty = 0;

    scytale_transposition_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still due", cycle_count,
                     pending_text.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when a test asks for one
    always @(negedge clk)
    begin
        if (rx_hold_len != 0)
        begin
            rx_hold_left = rx_hold_len;
            rx_hold_len  = 0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            if (error_count < PRINT_LIMIT)
                $display("MISMATCH word %0d %s: got 0x%0h, want 0x%0h", words_checked, what,
                         got, want);
            error_count++;
        end
    endtask

    // Output checker: every accepted word against the oldest pending one
    always @(posedge clk)
    begin
        sct_pkg::out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_text.size() == 0)
                report_mismatch("unexpected word", int'(out_data), 0);
            else
            begin
                want = pending_text.pop_front();
                if (out_data.out_char !== want.out_char)
                    report_mismatch("out_char", int'(out_data.out_char),
                                    int'(want.out_char));
                if (out_data.out_last !== want.out_last)
                    report_mismatch("out_last", int'(out_data.out_last),
                                    int'(want.out_last));
                if (out_data.truncated !== want.truncated)
                    report_mismatch("truncated", int'(out_data.truncated),
                                    int'(want.truncated));
            end
            words_checked++;
        end
    end

    // Transpose the held message and queue the words it must produce
    task automatic transpose_message();
        logic [7:0]         text [STORE_DEPTH];
        logic [7:0]         grid [STORE_DEPTH][STORE_DEPTH];
        sct_pkg::out_word_t words [$];
        sct_pkg::out_word_t w;
        int                 n, rows, cols, full, pos, row_len;
        begin
            if (cfg_rows == '0)
                rows = 1;
            else if (cfg_rows > sct_pkg::MAX_ROWS)
                rows = int'(sct_pkg::MAX_ROWS);
            else
                rows = int'(cfg_rows);
            n = 0;
            w.out_last  = 1'b0;
            w.truncated = msg_dropped;
            if (cfg_mode == sct_pkg::MODE_DECRYPT)
            begin
                // fill column by column, read the filled cells row by row
                n = msg_len;
                cols = (n + rows - 1) / rows;
                for (int r = 0; r < rows; r++)
                    for (int c = 0; c < cols; c++)
                        if (c * rows + r < n)
                        begin
                            w.out_char = msg_bytes[c * rows + r];
                            words.push_back(w);
                        end
            end
            else
            begin
                // drop spaces, fill rows with '@' pads on the short ones, read by column
                for (int i = 0; i < msg_len; i++)
                    if (msg_bytes[i] != sct_pkg::SPACE_CHAR)
                    begin
                        text[n] = msg_bytes[i];
                        n++;
                    end
                if (n > 0)
                begin
                    cols = (n + rows - 1) / rows;
                    full = rows - (rows * cols - n);
                    pos = 0;
                    for (int r = 0; r < rows; r++)
                    begin
                        row_len = (r < full) ? cols : cols - 1;
                        for (int c = 0; c < cols; c++)
                            if (c < row_len && pos < n)
                            begin
                                grid[r][c] = text[pos];
                                pos++;
                            end
                            else
                                grid[r][c] = sct_pkg::PAD_CHAR;
                    end
                    for (int c = 0; c < cols; c++)
                        for (int r = 0; r < rows; r++)
                        begin
                            w.out_char = grid[r][c];
                            words.push_back(w);
                        end
                end
            end
            if (words.size() > 0)
                words[words.size() - 1].out_last = 1'b1;
            else
                messages_empty++;
            foreach (words[i])
                pending_text.push_back(words[i]);
            if (msg_dropped)
                messages_cut++;
            messages_sent++;
            msg_len     = 0;
            msg_dropped = 1'b0;
        end
    endtask

    // Send one byte; called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] ch, input logic last);
        int gap;
        begin
            gap = 0;
            while ($urandom_range(0, 99) < tx_idle_pct)
                gap++;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= '{in_char: ch, in_last: last};
            do @(posedge clk); while (!in_ready);
            if (msg_len < STORE_DEPTH)
            begin
                msg_bytes[msg_len] = ch;
                msg_len++;
            end
            else
                msg_dropped = 1'b1;
            if (last)
                transpose_message();
            @(negedge clk);
        end
    endtask

    task automatic send_text(input string s);
        begin
            for (int i = 0; i < s.len(); i++)
                send_byte(s[i], i == s.len() - 1);
        end
    endtask

    // Message byte with plenty of spaces and pads mixed in
    function automatic logic [7:0] message_char();
        int pick;
        begin
            pick = $urandom_range(0, 19);
            if (pick < 5)
                return sct_pkg::SPACE_CHAR;
            else if (pick < 7)
                return sct_pkg::PAD_CHAR;
            return 8'($urandom_range(0, 255));
        end
    endfunction

    task automatic wait_results_done();
        begin
            in_valid <= 1'b0;
            while (pending_text.size() != 0)
                @(negedge clk);
        end
    endtask

    // Idle: no word due and the block has had time to finish an empty message
    task automatic wait_for_quiet();
        begin
            wait_results_done();
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    // Leaves cfg_valid high; the caller drops it after its last write
    task automatic write_register(input logic [sct_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [sct_pkg::CFG_DATA_W-1:0] value);
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= value;
            do @(posedge clk); while (!cfg_ready);
            if (idx == sct_pkg::REG_MODE)
                cfg_mode = value[0];
            else
                cfg_rows = value;
            @(negedge clk);
        end
    endtask

    task automatic set_config(input logic mode, input logic [sct_pkg::ROW_W-1:0] rows);
        begin
            wait_for_quiet();
            write_register(sct_pkg::REG_MODE, sct_pkg::CFG_DATA_W'(mode));
            write_register(sct_pkg::REG_KEY_ROWS, rows);
            cfg_valid <= 1'b0;
        end
    endtask

    // Byte extremes, zero and oversize keys, empty text, pads, partial columns
    task automatic test_directed();
        begin
            set_config(sct_pkg::MODE_ENCRYPT, 6'd0);
            send_byte(8'h00, 1'b0);
            send_byte(8'hFF, 1'b1);
            set_config(sct_pkg::MODE_ENCRYPT, 6'd3);
            send_text("HI THERE");
            send_text(" ");
            set_config(sct_pkg::MODE_ENCRYPT, 6'd63);
            send_text("ab");
            set_config(sct_pkg::MODE_DECRYPT, 6'd4);
            send_text("SCYTALE@X");
        end
    endtask

    // Messages longer than the buffer, at the largest and smallest key
    task automatic test_overflow();
        begin
            set_config(sct_pkg::MODE_ENCRYPT, sct_pkg::MAX_ROWS);
            for (int i = 0; i < 33; i++)
                send_byte(8'($urandom_range(33, 255)), i == 32);
            set_config(sct_pkg::MODE_DECRYPT, 6'd1);
            for (int i = 0; i < 33; i++)
                send_byte(message_char(), i == 32);
        end
    endtask

    // Random messages, mostly short, with occasional key and mode changes
    task automatic test_random_messages(input int item_budget);
        int                        sent, len;
        logic                      all_blank;
        logic [sct_pkg::ROW_W-1:0] rows;
        begin
            sent = 0;
            while (sent < item_budget)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    case ($urandom_range(0, 7))
                        0:       rows = 6'd0;
                        1:       rows = 6'd1;
                        2:       rows = sct_pkg::MAX_ROWS;
                        3:       rows = 6'd63;
                        4:       rows = 6'($urandom_range(1, 33));
                        default: rows = 6'($urandom_range(2, 8));
                    endcase
                    set_config(logic'($urandom_range(0, 1)), rows);
                end
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 36) : $urandom_range(1, 10);
                if (len > item_budget - sent)
                    len = item_budget - sent;
                all_blank = (cfg_mode == sct_pkg::MODE_ENCRYPT) && ($urandom_range(0, 9) == 0);
                for (int i = 0; i < len; i++)
                    send_byte(all_blank ? sct_pkg::SPACE_CHAR : message_char(), i == len - 1);
                sent += len;
            end
        end
    endtask

    // Long receiver hold-off while messages keep coming, so the input backs up
    task automatic test_backpressure();
        begin
            set_config(sct_pkg::MODE_ENCRYPT, 6'd5);
            rx_hold_len = 400;
            for (int m = 0; m < 2; m++)
                for (int i = 0; i < 6; i++)
                    send_byte(8'($urandom_range(0, 255)), i == 5);
        end
    endtask

    // Sender stops until every word of the previous message is out
    task automatic test_pause_until_drained();
        begin
            set_config(sct_pkg::MODE_DECRYPT, 6'd3);
            for (int m = 0; m < 2; m++)
            begin
                for (int i = 0; i < 4; i++)
                    send_byte(message_char(), i == 3);
                wait_results_done();
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        tx_idle_pct = 12;
        rx_idle_pct = 45;
        test_directed();
        test_overflow();
        test_random_messages(4);

        tx_idle_pct = 45;
        rx_idle_pct = 12;
        test_backpressure();
        test_random_messages(4);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_pause_until_drained();
        test_random_messages(4);

        wait_for_quiet();
        $display("Sent %0d messages (%0d over buffer depth, %0d giving no text), %0d words checked",
                 messages_sent, messages_cut, messages_empty, words_checked);
        $display("Both modes, keys 0 to 63, stalls on either side and a long output hold-off");
        if (error_count == 0 && pending_text.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/sct_pkg.sv
design/sct_buf.sv
design/sct_seq.sv
design/scytale_transposition_unit.sv
tb/tb_scytale_transposition_unit.sv
